// ===== rtl/stid_pkg.sv =====
// ----------------------------------------------------------------------------
// stid_pkg
// Shared types and codes for the sorted table insert/delete core.
// ----------------------------------------------------------------------------
`default_nettype none

package stid_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int VALUE_W          = 32;
    localparam int INDEX_W          = 4;
    localparam int SIZE_W           = 5;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic [1:0]                 mode;
        logic signed [VALUE_W-1:0]  value;
        logic [INDEX_W-1:0]         index;
    } cmd_t;

    typedef struct packed {
        logic [1:0]                 status;
        logic signed [VALUE_W-1:0]  read_value;
        logic [SIZE_W-1:0]          size;
    } result_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic                       ins;
        logic                       del;
        logic                       found;
        logic signed [VALUE_W-1:0]  key;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/stid_cell.sv =====
// ----------------------------------------------------------------------------
// stid_cell
// One slot of the sorted table: holds an entry, compares it with the key,
// and takes the key or a neighbor's entry on insert/delete.
// ----------------------------------------------------------------------------
`default_nettype none

module stid_cell (
    input  wire logic                              clk,
    input  wire stid_pkg::cell_ctrl_t              ctrl,
    input  wire logic                              valid,
    input  wire logic signed [stid_pkg::VALUE_W-1:0] left_value,
    input  wire logic                              left_less,
    input  wire logic signed [stid_pkg::VALUE_W-1:0] right_value,
    output logic signed [stid_pkg::VALUE_W-1:0]    value,
    output logic                                   less,
    output logic                                   eq
);
    import stid_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    assign value = value_reg;
    assign less  = valid && (value_reg < ctrl.key);
    assign eq    = valid && (value_reg == ctrl.key);

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins && !less)
        begin
            value_next = left_less ? ctrl.key : left_value;
        end
        else if (ctrl.del && ctrl.found && valid && !less)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

// ===== rtl/sorted_table_insert_delete_core.sv =====
// ----------------------------------------------------------------------------
// sorted_table_insert_delete_core
// Bounded table of signed 32-bit values kept in ascending order, built as a
// row of cells that shift toward or away from the insert/delete point.
//
// Usage:
//   A command beat (mode, value, index) is taken at a rising edge where
//   start is high and busy is low. busy never rises: every cell compares
//   its entry with the key in parallel and updates in the same cycle, so
//   a new command may be issued every cycle.
//   The result beat (status, read_value, size) appears on result for one
//   cycle, marked by strobe, in the cycle after the command edge.
//   Throughput: 1 command per cycle, set by the single compare-and-shift
//   step of the cell row.
//   Insert lands ahead of equal entries; delete removes the first equal
//   entry. Insert into a full table reports ST_FULL, delete of a missing
//   value ST_NOT_FOUND, read past the count ST_RANGE.
//   The receiver cannot stall; results must be taken when strobe is high.
//   Reset empties the table (count to zero) and drops strobe; entry
//   contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_insert_delete_core #(
    parameter int CAPACITY = stid_pkg::DEFAULT_CAPACITY
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire stid_pkg::cmd_t    cmd,
    output logic                   strobe,
    output stid_pkg::result_t      result
);
    import stid_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > INDEX_W) ? CW : INDEX_W) + 1;

    logic                       accept;
    cell_ctrl_t                 ctrl;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic                       strobe_reg;
    result_t                    result_reg;
    result_t                    result_next;
    logic                       full;
    logic                       found;
    logic                       in_range;
    logic signed [VALUE_W-1:0]  rd_value;

    logic signed [VALUE_W-1:0]  cell_value [CAPACITY];
    logic                       cell_less  [CAPACITY];
    logic                       cell_eq    [CAPACITY];
    logic [CAPACITY-1:0]        eq_vec;
    logic signed [VALUE_W-1:0]  rd_term    [CAPACITY];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CW'(CAPACITY));
    assign found  = |eq_vec;

    always_comb
    begin
        ctrl.key   = cmd.value;
        ctrl.ins   = accept && (cmd.mode == MODE_INSERT) && !full;
        ctrl.del   = accept && (cmd.mode == MODE_DELETE);
        ctrl.found = found;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [VALUE_W-1:0] left_value;
            logic                      left_less;
            logic signed [VALUE_W-1:0] right_value;
            logic                      valid;

            if (gi == 0)
            begin : g_first
                assign left_value = cmd.value;
                assign left_less  = 1'b1;
            end
            else
            begin : g_inner
                assign left_value = cell_value[gi-1];
                assign left_less  = cell_less[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_value = cell_value[gi];
            end
            else
            begin : g_mid
                assign right_value = cell_value[gi+1];
            end

            assign valid      = (count_reg > CW'(gi));
            assign eq_vec[gi] = cell_eq[gi];
            assign rd_term[gi] = (valid && (XW'(cmd.index) == XW'(gi))) ?
                                 cell_value[gi] : '0;

            stid_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .valid       (valid),
                .left_value  (left_value),
                .left_less   (left_less),
                .right_value (right_value),
                .value       (cell_value[gi]),
                .less        (cell_less[gi]),
                .eq          (cell_eq[gi])
            );
        end
    endgenerate

    always_comb
    begin
        rd_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_value = rd_value | rd_term[i];
        end
    end

    assign in_range = (XW'(cmd.index) < XW'(count_reg));

    always_comb
    begin
        count_next             = count_reg;
        result_next.status     = ST_OK;
        result_next.read_value = '0;
        if (accept)
        begin
            unique case (cmd.mode)
                MODE_INSERT:
                begin
                    if (full)
                    begin
                        result_next.status = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                MODE_DELETE:
                begin
                    if (found)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    else
                    begin
                        result_next.status = ST_NOT_FOUND;
                    end
                end
                MODE_READ:
                begin
                    if (in_range)
                    begin
                        result_next.read_value = rd_value;
                    end
                    else
                    begin
                        result_next.status = ST_RANGE;
                    end
                end
                default:
                begin
                    result_next.status = ST_OK;
                end
            endcase
        end
        result_next.size = SIZE_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            strobe_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    // count stays within the table
    a_count_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY)
    ) else $error("entry count exceeds capacity");

    // a result beat only follows an accepted command
    a_strobe_follows: assert property (
        @(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(accept)
    ) else $error("result beat without command");

    // rejected insert only when full, and reported size is the capacity
    a_full_size: assert property (
        @(posedge clk) disable iff (!rst_n)
        (strobe_reg && (result_reg.status == ST_FULL)) |->
            (result_reg.size == SIZE_W'(CAPACITY))
    ) else $error("full status with wrong size");

    // successful insert grows the table by one
    a_insert_grows: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && (cmd.mode == MODE_INSERT) && !full) |=>
            (count_reg == $past(count_reg) + CW'(1))
    ) else $error("insert did not grow count");

    // failed reads return zero
    a_range_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (strobe_reg && (result_reg.status == ST_RANGE)) |->
            (result_reg.read_value == '0)
    ) else $error("out-of-range read returned data");

endmodule

`default_nettype wire
